// ===== rtl/hpng_pkg.sv =====
// Shared constants, register map and control structs for the high-pass noise gate.
package hpng_pkg;

	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_COEF_BITS   = 16;
	localparam int MAX_CHANNELS    = 2;

	// register indexes, paddr[4:2]
	localparam logic [2:0] REG_CHANNELS  = 3'd0;
	localparam logic [2:0] REG_HP_COEFF  = 3'd1;
	localparam logic [2:0] REG_ATTACK    = 3'd2;
	localparam logic [2:0] REG_RELEASE   = 3'd3;
	localparam logic [2:0] REG_OPEN_LVL  = 3'd4;

	localparam int RST_CHANNELS  = 2;
	localparam int RST_HP_COEFF  = 32363;
	localparam int RST_ATTACK    = 32540;
	localparam int RST_RELEASE   = 32759;
	localparam int RST_OPEN_LVL  = 0;

	typedef struct packed {
		logic start;
		logic out_free;
	} core_ctrl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} core_stat_t;

endpackage

// ===== rtl/hpng_core.sv =====
// Sequencer and shared-multiplier datapath: high-pass, RMS, envelope, gate gain, gating.
module hpng_core import hpng_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS   = DEF_COEF_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  core_ctrl_t                    ctrl,
	output core_stat_t                    stat,
	input  logic signed [SAMPLE_BITS-1:0] sample_a,
	input  logic signed [SAMPLE_BITS-1:0] sample_b,
	input  logic                          block_end_in,
	input  logic                          stereo,
	input  logic [COEF_BITS-2:0]          hp_coeff,
	input  logic [COEF_BITS-2:0]          attack_coeff,
	input  logic [COEF_BITS-2:0]          release_coeff,
	input  logic [SAMPLE_BITS-2:0]        open_level,
	output logic signed [SAMPLE_BITS-1:0] out_a,
	output logic signed [SAMPLE_BITS-1:0] out_b,
	output logic [COEF_BITS-1:0]          gain_now,
	output logic                          block_end_out
);

	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = COEF_BITS;
	localparam int FRAC = CB - 1;
	localparam int MXW  = (SB > CB) ? SB : CB;
	localparam int AW   = MXW + 2;
	localparam int BW   = MXW + 1;
	localparam int PW   = AW + BW;
	localparam int RW   = SB + 2;
	localparam int CW   = $clog2(SB);
	localparam int IW   = $clog2(MAX_CHANNELS);

	localparam logic [CB-1:0]        UNITY  = CB'(1) << (CB - 1);
	localparam logic signed [SB-1:0] SMAX_S = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [PW-1:0] SMAX_W = PW'(SMAX_S);
	localparam logic signed [PW-1:0] SMIN_W = PW'(~SMAX_S);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_HP_MUL   = 4'd1;
	localparam logic [3:0] ST_HP_SAT   = 4'd2;
	localparam logic [3:0] ST_SQ       = 4'd3;
	localparam logic [3:0] ST_SQ_ACC   = 4'd4;
	localparam logic [3:0] ST_ROOT     = 4'd5;
	localparam logic [3:0] ST_ENV_MUL1 = 4'd6;
	localparam logic [3:0] ST_ENV_MUL2 = 4'd7;
	localparam logic [3:0] ST_ENV_SUM  = 4'd8;
	localparam logic [3:0] ST_GAIN_MUL = 4'd9;
	localparam logic [3:0] ST_GAIN_SUM = 4'd10;
	localparam logic [3:0] ST_OUT_MUL  = 4'd11;
	localparam logic [3:0] ST_OUT_SAT  = 4'd12;
	localparam logic [3:0] ST_DONE     = 4'd13;

	logic [3:0]              state_q;
	logic [IW-1:0]           ch_q;
	logic [CW-1:0]           cnt_q;
	logic signed [SB-1:0]    hin_q  [MAX_CHANNELS];
	logic signed [SB-1:0]    hout_q [MAX_CHANNELS];
	logic [SB-2:0]           env_q;
	logic [CB-1:0]           gain_q;

	logic                    stereo_q;
	logic                    last_q;
	logic signed [SB-1:0]    x_q [MAX_CHANNELS];
	logic signed [SB-1:0]    h_q [MAX_CHANNELS];
	logic signed [SB-1:0]    y_q [MAX_CHANNELS];
	logic signed [PW-1:0]    prod_q;
	logic signed [PW-1:0]    acc_q;
	logic [2*SB-1:0]         rad_q;
	logic [RW-1:0]           rem_q;
	logic [SB-1:0]           root_q;
	logic [CB-2:0]           k_q;
	logic                    tgt_q;

	logic signed [AW-1:0]    mul_a;
	logic signed [BW-1:0]    mul_b;
	logic signed [PW-1:0]    shr;
	logic signed [SB-1:0]    sat_y;
	logic signed [PW-1:0]    sq_sum;
	logic signed [PW-1:0]    env_sum;
	logic [RW-1:0]           rem_sh;
	logic [RW-1:0]           trial;
	logic                    fits;
	logic [SB-2:0]           rms;
	logic                    env_up;
	logic                    gate_open;
	logic [CB-2:0]           env_k;
	logic [CB-2:0]           gain_k;
	logic [CB-1:0]           gain_new;
	logic                    last_ch;

	assign last_ch = !stereo_q || (ch_q == IW'(1));

	// floor shift and saturate, used by the filter and by the gated output
	always_comb begin
		shr = prod_q >>> FRAC;
		if (shr > SMAX_W) begin
			sat_y = SMAX_S;
		end else if (shr < SMIN_W) begin
			sat_y = ~SMAX_S;
		end else begin
			sat_y = shr[SB-1:0];
		end
	end

	assign sq_sum  = ((ch_q == '0) ? PW'(0) : acc_q) + prod_q;
	assign env_sum = acc_q + prod_q;

	// one bit of the square root per cycle
	assign rem_sh = {rem_q[RW-3:0], rad_q[2*SB-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	assign rms       = root_q[SB-1] ? {(SB-1){1'b1}} : root_q[SB-2:0];
	assign env_up    = rms > env_q;
	assign env_k     = env_up ? attack_coeff : release_coeff;
	assign gate_open = env_q > open_level;
	assign gain_k    = (gate_open && (UNITY > gain_q)) ? attack_coeff : release_coeff;
	// target is either zero or unity, so its product is a plain term
	assign gain_new  = prod_q[FRAC +: CB] + (tgt_q ? (UNITY - CB'(k_q)) : CB'(0));

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_HP_MUL: begin
				mul_a = AW'(hout_q[ch_q]) + AW'(x_q[ch_q]) - AW'(hin_q[ch_q]);
				mul_b = BW'(hp_coeff);
			end
			ST_SQ: begin
				mul_a = AW'(h_q[ch_q]);
				mul_b = BW'(h_q[ch_q]);
			end
			ST_ENV_MUL1: begin
				mul_a = AW'(env_q);
				mul_b = BW'(env_k);
			end
			ST_ENV_MUL2: begin
				mul_a = AW'(rms);
				mul_b = BW'(UNITY - CB'(k_q));
			end
			ST_GAIN_MUL: begin
				mul_a = AW'(gain_k);
				mul_b = BW'(gain_q);
			end
			ST_OUT_MUL: begin
				mul_a = AW'(h_q[ch_q]);
				mul_b = BW'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			cnt_q   <= '0;
			env_q   <= '0;
			gain_q  <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				hin_q[i]  <= '0;
				hout_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						ch_q    <= '0;
						state_q <= ST_HP_MUL;
					end
				end
				ST_HP_MUL: state_q <= ST_HP_SAT;
				ST_HP_SAT: begin
					hin_q[ch_q]  <= x_q[ch_q];
					hout_q[ch_q] <= sat_y;
					state_q      <= ST_SQ;
				end
				ST_SQ: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					if (last_ch) begin
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end else begin
						ch_q    <= ch_q + IW'(1);
						state_q <= ST_HP_MUL;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(SB - 1)) begin
						state_q <= ST_ENV_MUL1;
					end
				end
				ST_ENV_MUL1: state_q <= ST_ENV_MUL2;
				ST_ENV_MUL2: state_q <= ST_ENV_SUM;
				ST_ENV_SUM: begin
					env_q   <= env_sum[FRAC +: SB-1];
					state_q <= ST_GAIN_MUL;
				end
				ST_GAIN_MUL: state_q <= ST_GAIN_SUM;
				ST_GAIN_SUM: begin
					gain_q  <= gain_new;
					ch_q    <= '0;
					state_q <= ST_OUT_MUL;
				end
				ST_OUT_MUL: state_q <= ST_OUT_SAT;
				ST_OUT_SAT: begin
					if (last_ch) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + IW'(1);
						state_q <= ST_OUT_MUL;
					end
				end
				ST_DONE: begin
					if (ctrl.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					x_q[0]   <= sample_a;
					x_q[1]   <= sample_b;
					last_q   <= block_end_in;
					stereo_q <= stereo;
				end
			end
			ST_HP_SAT: h_q[ch_q] <= sat_y;
			ST_SQ_ACC: begin
				acc_q  <= sq_sum;
				rad_q  <= stereo_q ? sq_sum[2*SB:1] : sq_sum[2*SB-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= fits ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[SB-2:0], fits};
			end
			ST_ENV_MUL1: k_q <= env_k;
			ST_ENV_MUL2: acc_q <= prod_q;
			ST_GAIN_MUL: begin
				k_q   <= gain_k;
				tgt_q <= gate_open;
			end
			ST_OUT_SAT: y_q[ch_q] <= sat_y;
			default: begin
			end
		endcase
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE) && ctrl.out_free;

	assign out_a         = y_q[0];
	assign out_b         = stereo_q ? y_q[1] : '0;
	assign gain_now      = gain_q;
	assign block_end_out = last_q;

endmodule

// ===== rtl/highpass_noise_gate.sv =====
// Top level: audio noise gate with high-pass filter, envelope follower and gate smoothing.
//
// Usage:
//   s_* stream: one frame per transaction, tdata = {sample_b, sample_a}, tlast marks the
//   last frame of a software buffer. In mono, sample_b is ignored.
//   m_* stream: one result per frame, tdata = {gain_now, out_b, out_a}, tlast copied.
//   APB port: channels_in_use at 0x00, hp_coeff 0x04, attack_coeff 0x08,
//   release_coeff 0x0C, open_level 0x10; write only while no frame is in flight.
// Operation: a frame is worked on by one shared multiplier and a one-bit-per-cycle square
//   root. A new frame is accepted only after the previous result has been handed to the
//   output register. s_tready is high only while the sequencer idles.
// Reset: filter history, envelope and gate gain clear (gate closed); registers return
//   to stereo and the default coefficients, open level zero.
// Stall: a result waits in the output register; the next frame is still accepted and
//   computed, and its last step holds until the output register frees.
module highpass_noise_gate import hpng_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS   = DEF_COEF_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       psel,
	input  logic                                       penable,
	input  logic                                       pwrite,
	input  logic [4:0]                                 paddr,
	input  logic [31:0]                                pwdata,
	output logic [31:0]                                prdata,
	output logic                                       pready,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// sample_a, sample_b
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,
	input  logic                                       s_tlast,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// out_a, out_b, gain_now
	output logic [((2*SAMPLE_BITS+COEF_BITS+7)/8)*8-1:0] m_tdata,
	output logic                                       m_tlast
);

	localparam int SB    = SAMPLE_BITS;
	localparam int CB    = COEF_BITS;
	localparam int KW    = CB - 1;
	localparam int OUT_W = ((2*SB+CB+7)/8)*8;
	localparam logic [CB-1:0] UNITY = CB'(1) << (CB - 1);

	logic [1:0]    chan_q;
	logic [KW-1:0] hp_coeff_q;
	logic [KW-1:0] attack_q;
	logic [KW-1:0] release_q;
	logic [SB-2:0] open_lvl_q;
	logic          cfg_wr;

	core_ctrl_t ctrl;
	core_stat_t stat;

	logic signed [SB-1:0] core_a;
	logic signed [SB-1:0] core_b;
	logic [CB-1:0]        core_gain;
	logic                 core_last;

	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;
	logic                 m_tlast_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q     <= 2'(RST_CHANNELS);
			hp_coeff_q <= KW'(RST_HP_COEFF);
			attack_q   <= KW'(RST_ATTACK);
			release_q  <= KW'(RST_RELEASE);
			open_lvl_q <= (SB-1)'(RST_OPEN_LVL);
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_CHANNELS: chan_q     <= pwdata[1:0];
				REG_HP_COEFF: hp_coeff_q <= pwdata[KW-1:0];
				REG_ATTACK:   attack_q   <= pwdata[KW-1:0];
				REG_RELEASE:  release_q  <= pwdata[KW-1:0];
				REG_OPEN_LVL: open_lvl_q <= pwdata[SB-2:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_CHANNELS: prdata = 32'(chan_q);
			REG_HP_COEFF: prdata = 32'(hp_coeff_q);
			REG_ATTACK:   prdata = 32'(attack_q);
			REG_RELEASE:  prdata = 32'(release_q);
			REG_OPEN_LVL: prdata = 32'(open_lvl_q);
			default:      prdata = '0;
		endcase
	end

	assign s_tready      = stat.idle;
	assign ctrl.start    = s_tvalid && s_tready;
	assign ctrl.out_free = !m_tvalid_q || m_tready;

	hpng_core #(
		.SAMPLE_BITS(SB),
		.COEF_BITS  (CB)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.sample_a     (s_tdata[SB-1:0]),
		.sample_b     (s_tdata[2*SB-1:SB]),
		.block_end_in (s_tlast),
		// count of 2 or 3 runs stereo, 0 or 1 runs mono
		.stereo       (chan_q[1]),
		.hp_coeff     (hp_coeff_q),
		.attack_coeff (attack_q),
		.release_coeff(release_q),
		.open_level   (open_lvl_q),
		.out_a        (core_a),
		.out_b        (core_b),
		.gain_now     (core_gain),
		.block_end_out(core_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			m_tdata_q <= OUT_W'({core_gain, core_b, core_a});
			m_tlast_q <= core_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// a result is only handed over when the output register can take it
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (!m_tvalid_q || m_tready))
		else $error("result handed over while output register full");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> m_tvalid)
		else $error("finished frame did not reach the output");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("sequencer not busy after accepting a frame");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*SB +: CB] <= UNITY))
		else $error("gate gain above unity");

endmodule
